[src/i2ctw_pkg.sv]
// shared types, constants and the sequencer microprogram for the i2c timing calculator
package i2ctw_pkg;

  // operand widths of the shared divider
  localparam int NUM_W = 39;   // kernel clock times the longest delay in ns
  localparam int DEN_W = 34;   // one second in ns times the largest prescaler

  localparam int CLK_W = 30;
  localparam int PRE_W = 4;
  localparam int CODE_W = 4;
  localparam int COUNT_W = 8;
  localparam int STATUS_W = 2;
  localparam int NS_W = 9;
  localparam int BUS2_W = 20;
  localparam int PC_W = 4;

  localparam int PRESCALER_STEPS_DEF = 16;

  // twice the bus frequency, so the divisor is one product
  localparam logic [BUS2_W-1:0] STD_BUS2_HZ = 20'd200000;
  localparam logic [BUS2_W-1:0] FAST_BUS2_HZ = 20'd800000;
  localparam logic [NS_W-1:0] STD_SETUP_NS = 9'd500;
  localparam logic [NS_W-1:0] FAST_SETUP_NS = 9'd125;
  localparam logic [NS_W-1:0] HOLD_NS = 9'd100;
  localparam logic [CLK_W-1:0] NS_PER_S = 30'd1000000000;
  localparam logic [NUM_W-1:0] HALF_MIN = 39'd2;
  localparam logic [NUM_W-1:0] HALF_MAX = 39'd256;
  localparam logic [NUM_W-1:0] SETUP_MAX = 39'd16;
  localparam logic [NUM_W-1:0] HOLD_MAX = 39'd15;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;

  // datapath actions
  localparam logic [3:0] A_NONE = 4'd0;
  localparam logic [3:0] A_START_PRE = 4'd1;
  localparam logic [3:0] A_SAVE_HALF = 4'd2;
  localparam logic [3:0] A_NEXT_PRE = 4'd3;
  localparam logic [3:0] A_START_SETUP = 4'd4;
  localparam logic [3:0] A_START_HOLD = 4'd5;
  localparam logic [3:0] A_FINISH = 4'd6;
  localparam logic [3:0] A_BAD_ARG = 4'd7;
  localparam logic [3:0] A_UNSUP = 4'd8;

  // jump conditions
  localparam logic [2:0] C_NEVER = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_NO_INPUT = 3'd2;
  localparam logic [2:0] C_ZERO_CLK = 3'd3;
  localparam logic [2:0] C_DIV_BUSY = 3'd4;
  localparam logic [2:0] C_HALF_OK = 3'd5;
  localparam logic [2:0] C_LAST_PRE = 3'd6;
  localparam logic [2:0] C_OUT_FULL = 3'd7;

  // program addresses
  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_CHECK = 4'd1;
  localparam logic [PC_W-1:0] S_PRE = 4'd2;
  localparam logic [PC_W-1:0] S_PRE_WAIT = 4'd3;
  localparam logic [PC_W-1:0] S_PRE_TEST = 4'd4;
  localparam logic [PC_W-1:0] S_PRE_NEXT = 4'd5;
  localparam logic [PC_W-1:0] S_PRE_LOOP = 4'd6;
  localparam logic [PC_W-1:0] S_SETUP = 4'd7;
  localparam logic [PC_W-1:0] S_SETUP_WAIT = 4'd8;
  localparam logic [PC_W-1:0] S_HOLD = 4'd9;
  localparam logic [PC_W-1:0] S_HOLD_WAIT = 4'd10;
  localparam logic [PC_W-1:0] S_RESULT = 4'd11;
  localparam logic [PC_W-1:0] S_RET_OK = 4'd12;
  localparam logic [PC_W-1:0] S_BAD = 4'd13;
  localparam logic [PC_W-1:0] S_RET_BAD = 4'd14;
  localparam logic [PC_W-1:0] S_UNSUP = 4'd15;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // jump to target when cond holds, otherwise step on
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      S_IDLE:       w = '{A_NONE, C_NO_INPUT, S_IDLE};
      S_CHECK:      w = '{A_NONE, C_ZERO_CLK, S_BAD};
      S_PRE:        w = '{A_START_PRE, C_NEVER, S_IDLE};
      S_PRE_WAIT:   w = '{A_NONE, C_DIV_BUSY, S_PRE_WAIT};
      S_PRE_TEST:   w = '{A_SAVE_HALF, C_HALF_OK, S_SETUP};
      S_PRE_NEXT:   w = '{A_NEXT_PRE, C_LAST_PRE, S_UNSUP};
      S_PRE_LOOP:   w = '{A_NONE, C_ALWAYS, S_PRE};
      S_SETUP:      w = '{A_START_SETUP, C_NEVER, S_IDLE};
      S_SETUP_WAIT: w = '{A_NONE, C_DIV_BUSY, S_SETUP_WAIT};
      S_HOLD:       w = '{A_START_HOLD, C_NEVER, S_IDLE};
      S_HOLD_WAIT:  w = '{A_NONE, C_DIV_BUSY, S_HOLD_WAIT};
      S_RESULT:     w = '{A_FINISH, C_OUT_FULL, S_RESULT};
      S_RET_OK:     w = '{A_NONE, C_ALWAYS, S_IDLE};
      S_BAD:        w = '{A_BAD_ARG, C_OUT_FULL, S_BAD};
      S_RET_BAD:    w = '{A_NONE, C_ALWAYS, S_IDLE};
      // last step: the step counter wraps back to idle
      S_UNSUP:      w = '{A_UNSUP, C_OUT_FULL, S_UNSUP};
    endcase
    return w;
  endfunction

endpackage

[src/i2ctw_div.sv]
// shared restoring divider, one quotient bit per cycle
module i2ctw_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic             rem_nz
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0] trial;
  logic fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      busy <= cnt != CNT_W'(1);
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      den_r <= den;
    end else if (busy) begin
      // partial remainder stays below the divisor, so it fits DEN_W bits
      rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rem_nz = |rem;

endmodule

[src/i2c_timing_word_calculator.sv]
// i2c master timing calculator: one request in, one set of timing fields out
//
// A request carries the kernel clock in Hz and the bus speed. A small microprogram
// drives one shared bit-serial divider: it tries the prescalers in turn until the
// SCL half period in prescaled ticks lands in 2..256, then converts the setup and hold
// delays to ticks. A zero clock is answered as a bad argument without a division. A new
// request is taken only once the previous result has been written to the output register,
// where it may still wait on the output side. Fields other than status are zero when
// status is not ok.
module i2c_timing_word_calculator
  import i2ctw_pkg::*;
#(
  parameter int PRESCALER_STEPS = PRESCALER_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // kernel_clock_hz [29:0], zero [31:30]
  input  logic        s_tuser,   // fast_mode [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // prescaler_code [3:0], setup_delay_code [7:4],
                                 // hold_delay_code [11:8], scl_high_count [19:12],
                                 // scl_low_count [27:20], status [29:28], zero [31:30]
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t uc;
  logic jump;

  logic [CLK_W-1:0] kclk;
  logic fast;
  logic [PRE_W-1:0] pre;
  logic [COUNT_W-1:0] half_m1;
  logic [CODE_W-1:0] setup_code;
  logic setup_bad;

  logic [PRE_W-1:0] o_pre;
  logic [CODE_W-1:0] o_setup;
  logic [CODE_W-1:0] o_hold;
  logic [COUNT_W-1:0] o_count;
  logic [STATUS_W-1:0] o_status;

  logic accept;
  logic out_full;
  logic out_write;

  logic div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic div_busy;
  logic [NUM_W-1:0] div_quo;
  logic div_rem_nz;
  logic [NUM_W-1:0] q_ceil;
  logic half_ok;
  logic [PRE_W:0] divide;
  logic [BUS2_W-1:0] bus2;
  logic [NS_W-1:0] setup_ns;

  assign uc = ucode_rom(pc);
  assign s_tready = pc == S_IDLE;
  assign accept = s_tvalid && s_tready;
  assign out_full = m_tvalid && !m_tready;
  assign out_write = !out_full &&
                     (uc.action == A_FINISH || uc.action == A_BAD_ARG ||
                      uc.action == A_UNSUP);

  assign divide = {1'b0, pre} + (PRE_W+1)'(1);
  assign bus2 = fast ? FAST_BUS2_HZ : STD_BUS2_HZ;
  assign setup_ns = fast ? FAST_SETUP_NS : STD_SETUP_NS;
  assign q_ceil = div_quo + NUM_W'(div_rem_nz);
  assign half_ok = q_ceil >= HALF_MIN && q_ceil <= HALF_MAX;

  always_comb begin
    unique case (uc.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !accept;
      C_ZERO_CLK: jump = kclk == '0;
      C_DIV_BUSY: jump = div_busy;
      C_HALF_OK:  jump = half_ok;
      C_LAST_PRE: jump = pre == PRE_W'(PRESCALER_STEPS - 1);
      C_OUT_FULL: jump = out_full;
    endcase
    pc_next = jump ? uc.target : pc + PC_W'(1);
  end

  // divider operands: ceil(clk / (2 bus p)) or ceil(clk ns / (1e9 p))
  always_comb begin
    div_start = 1'b0;
    div_num = {{(NUM_W-CLK_W){1'b0}}, kclk};
    div_den = DEN_W'({{(DEN_W-BUS2_W){1'b0}}, bus2} *
                     {{(DEN_W-PRE_W-1){1'b0}}, divide});
    unique case (uc.action)
      A_START_PRE: begin
        div_start = 1'b1;
      end
      A_START_SETUP, A_START_HOLD: begin
        div_start = 1'b1;
        div_num = NUM_W'({{(NUM_W-CLK_W){1'b0}}, kclk} *
                         {{(NUM_W-NS_W){1'b0}},
                          (uc.action == A_START_SETUP) ? setup_ns : HOLD_NS});
        div_den = DEN_W'({{(DEN_W-CLK_W){1'b0}}, NS_PER_S} *
                         {{(DEN_W-PRE_W-1){1'b0}}, divide});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  i2ctw_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (out_write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kclk <= s_tdata[CLK_W-1:0];
      fast <= s_tuser;
      pre <= '0;
    end
    unique case (uc.action)
      A_SAVE_HALF: begin
        half_m1 <= COUNT_W'(q_ceil - NUM_W'(1));
      end
      A_NEXT_PRE: begin
        pre <= pre + PRE_W'(1);
      end
      A_START_HOLD: begin
        // setup quotient is still in the divider while the hold division starts
        setup_bad <= q_ceil > SETUP_MAX;
        setup_code <= (q_ceil == '0) ? '0 : CODE_W'(q_ceil - NUM_W'(1));
      end
      A_FINISH: begin
        if (out_write) begin
          if (setup_bad || q_ceil > HOLD_MAX) begin
            o_pre <= '0;
            o_setup <= '0;
            o_hold <= '0;
            o_count <= '0;
            o_status <= ST_UNSUPPORTED;
          end else begin
            o_pre <= pre;
            o_setup <= setup_code;
            o_hold <= CODE_W'(q_ceil);
            o_count <= half_m1;
            o_status <= ST_OK;
          end
        end
      end
      A_BAD_ARG, A_UNSUP: begin
        if (out_write) begin
          o_pre <= '0;
          o_setup <= '0;
          o_hold <= '0;
          o_count <= '0;
          o_status <= (uc.action == A_BAD_ARG) ? ST_BAD_ARG : ST_UNSUPPORTED;
        end
      end
      default: begin
      end
    endcase
  end

  // high and low counts are the same value
  assign m_tdata = {2'b00, o_status, o_count, o_count, o_hold, o_setup, o_pre};

endmodule

[src/i2ctw_checker.sv]
// port-level checks for the i2c timing calculator, bound to the top level
module i2ctw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time goes through the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while sequencer busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[29:28] != 2'b11 && m_tdata[31:30] == 2'b00)
    else $error("bad status code or padding");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29:28] != 2'b00 |-> m_tdata[27:0] == 28'd0)
    else $error("fields not cleared on failure");

  a_ok_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29:28] == 2'b00 |->
      m_tdata[19:12] == m_tdata[27:20] && m_tdata[19:12] != 8'd0)
    else $error("scl counts inconsistent");

endmodule

bind i2c_timing_word_calculator i2ctw_checker u_i2ctw_checker (.*);

[bench/tb_i2c_timing_word_calculator.sv]
// self-checking bench for the i2c timing word calculator: predicted fields against the stream output
`timescale 1ns / 1ps

module tb_i2c_timing_word_calculator;
  import i2ctw_pkg::*;

  // result word as it sits on m_tdata, lowest field last
  typedef struct packed {
    logic [1:0]          pad;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  scl_low_count;
    logic [COUNT_W-1:0]  scl_high_count;
    logic [CODE_W-1:0]   hold_delay_code;
    logic [CODE_W-1:0]   setup_delay_code;
    logic [PRE_W-1:0]    prescaler_code;
  } timing_fields_t;

  class timing_scoreboard;
    timing_fields_t timing_q[$];
    int unsigned errors = 0;
    int unsigned seen = 0;
    int unsigned n_ok = 0;
    int unsigned n_zero_clk = 0;
    int unsigned n_unsup = 0;
    int unsigned n_fast = 0;

    static function longint unsigned ceil_div(longint unsigned num, longint unsigned den);
      return num / den + ((num % den) != 0 ? 1 : 0);
    endfunction

    static function timing_fields_t predict_timing(logic [CLK_W-1:0] hz, logic fast);
      timing_fields_t r;
      longint unsigned kc;
      longint unsigned bus2;
      longint unsigned setup_ns;
      longint unsigned half;
      longint unsigned t;
      longint unsigned setup_ticks;
      longint unsigned hold_ticks;
      int divide;
      r = '0;
      kc = hz;
      bus2 = fast ? FAST_BUS2_HZ : STD_BUS2_HZ;
      setup_ns = fast ? FAST_SETUP_NS : STD_SETUP_NS;
      divide = 0;
      half = 0;
      if (kc == 0) begin
        r.status = ST_BAD_ARG;
        return r;
      end
      for (int p = 1; p <= PRESCALER_STEPS_DEF; p++) begin
        t = ceil_div(kc, bus2 * p);
        if (t >= HALF_MIN && t <= HALF_MAX) begin
          divide = p;
          half = t;
          break;
        end
      end
      if (divide == 0) begin
        r.status = ST_UNSUPPORTED;
        return r;
      end
      setup_ticks = ceil_div(kc * setup_ns, longint'(NS_PER_S) * divide);
      hold_ticks = ceil_div(kc * HOLD_NS, longint'(NS_PER_S) * divide);
      if (setup_ticks == 0) setup_ticks = 1;
      if (setup_ticks > SETUP_MAX || hold_ticks > HOLD_MAX) begin
        r.status = ST_UNSUPPORTED;
        return r;
      end
      r.prescaler_code = PRE_W'(divide - 1);
      r.setup_delay_code = CODE_W'(setup_ticks - 1);
      r.hold_delay_code = CODE_W'(hold_ticks);
      r.scl_high_count = COUNT_W'(half - 1);
      r.scl_low_count = COUNT_W'(half - 1);
      r.status = ST_OK;
      return r;
    endfunction

    function void note_request(logic [CLK_W-1:0] hz, logic fast);
      timing_q.push_back(predict_timing(hz, fast));
      if (fast) n_fast++;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got)
        fail($sformatf("result %0d, %s: expected %0d, got %0d", seen, field, want, got));
    endfunction

    function void check_result(logic [31:0] word);
      timing_fields_t want;
      timing_fields_t got;
      got = timing_fields_t'(word);
      if (timing_q.size() == 0) begin
        fail($sformatf("unexpected result transfer, word %h", word));
        return;
      end
      want = timing_q.pop_front();
      compare_field("prescaler_code", want.prescaler_code, got.prescaler_code);
      compare_field("setup_delay_code", want.setup_delay_code, got.setup_delay_code);
      compare_field("hold_delay_code", want.hold_delay_code, got.hold_delay_code);
      compare_field("scl_high_count", want.scl_high_count, got.scl_high_count);
      compare_field("scl_low_count", want.scl_low_count, got.scl_low_count);
      compare_field("status", want.status, got.status);
      compare_field("upper pad bits", want.pad, got.pad);
      case (want.status)
        ST_OK: n_ok++;
        ST_BAD_ARG: n_zero_clk++;
        default: n_unsup++;
      endcase
      seen++;
    endfunction

    function int pending();
      return timing_q.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // kernel_clock_hz [29:0], zero [31:30]
  logic        s_tuser = 1'b0; // fast_mode [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // prescaler_code [3:0], setup_delay_code [7:4], hold_delay_code [11:8],
                         // scl_high_count [19:12], scl_low_count [27:20], status [29:28]

  timing_scoreboard sb;

  // corner clocks, each sent at both bus speeds
  longint unsigned corner_hz [12] = '{
    0, 1, 200001, 400000, 800001, 1600000, 8000000, 51200000,
    51200001, 100000000, 1000000000, 1073741823
  };

  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  i2c_timing_word_calculator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure: one of four ready patterns, picked anew at random
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 2) != 0);
      2: m_tready <= ((rx_cycle % 32) < 9);
      default: m_tready <= ((rx_cycle % 400) < 300);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata[CLK_W-1:0], s_tuser);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  task automatic send_request(logic [CLK_W-1:0] hz, logic fast);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, hz};
    s_tuser <= fast;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_cycles(int unsigned n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [CLK_W-1:0] pick_clock_hz(logic fast);
    int unsigned sel;
    longint unsigned base;
    sel = $urandom_range(0, 99);
    if (sel < 60) return CLK_W'($urandom_range(400000, 130000000));
    if (sel < 75) return CLK_W'($urandom);
    if (sel < 85) begin
      // just around a half-period edge of some prescaler
      base = (fast ? FAST_BUS2_HZ : STD_BUS2_HZ) * $urandom_range(1, 16)
             * $urandom_range(1, 257);
      return CLK_W'(base + $urandom_range(0, 2) - 1);
    end
    if (sel < 95) return CLK_W'($urandom_range(0, 2000000));
    return '0;
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned waited;
    logic fast;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_hz[i]) begin
      send_request(CLK_W'(corner_hz[i]), 1'b0);
      send_request(CLK_W'(corner_hz[i]), 1'b1);
    end
    drain_results();

    burst_left = $urandom_range(1, 8);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fast = $urandom_range(0, 1);
      send_request(pick_clock_hz(fast), fast);
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end else if (--burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
          0: gap = 0;
          1: gap = $urandom_range(1, 900);
          default: gap = $urandom_range(1, 30);
        endcase
        if (gap != 0) idle_cycles(gap);
      end
    end
    s_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1000) @(posedge clk);
    if (sb.pending() != 0) sb.fail($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d results: %0d ok, %0d zero clock, %0d unsupported; %0d at 400 kHz",
             sb.seen, sb.n_ok, sb.n_zero_clk, sb.n_unsup, sb.n_fast);
    $display("mismatches and other failures: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("tb_i2c_timing_word_calculator: done, clean");
    end else begin
      $display("tb_i2c_timing_word_calculator: done, errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb_i2c_timing_word_calculator: done, errors");
    $finish;
  end

endmodule
